/* sv/rssc_pkg.sv */
// Shared constants and types for the range-sum subarray counter.
// No dependencies.
package rssc_pkg;

  localparam int unsigned MAX_LEN = 1024;
  localparam int unsigned ADDR_W  = $clog2(MAX_LEN);
  localparam int unsigned CNT_W   = $clog2(MAX_LEN + 1);

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned DIFF_W  = SUM_W + 1;
  localparam int unsigned HERE_W  = 11;
  localparam int unsigned TOTAL_W = 20;
  localparam int unsigned PADDR_W = 3;

  localparam logic [HERE_W-1:0]  HERE_MAX  = {HERE_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // register select, taken from paddr[2]
  localparam logic REG_LOW  = 1'b0;
  localparam logic REG_HIGH = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [SUM_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  prefix;
    logic [DATA_W-1:0] low;
    logic [DATA_W-1:0] high;
  } cmp_req_t;

endpackage

/* sv/rssc_prefix_mem.sv */
// Prefix-sum store: one write port, one read port, registered read data.
// Depends on rssc_pkg.
module rssc_prefix_mem (
  input  logic                        clk_i,
  input  rssc_pkg::mem_req_t          req_i,
  output logic [rssc_pkg::SUM_W-1:0]  rdata_o
);

  logic [rssc_pkg::SUM_W-1:0] mem [rssc_pkg::MAX_LEN];
  logic [rssc_pkg::SUM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/rssc_range_unit.sv */
// Shared subtract-and-compare unit: tests low <= sum - prefix <= high.
// Depends on rssc_pkg.
module rssc_range_unit (
  input  rssc_pkg::cmp_req_t req_i,
  output logic               hit_o
);

  logic signed [rssc_pkg::DIFF_W-1:0] diff;
  logic signed [rssc_pkg::DIFF_W-1:0] low_ext;
  logic signed [rssc_pkg::DIFF_W-1:0] high_ext;

  assign diff = $signed({req_i.sum[rssc_pkg::SUM_W-1], req_i.sum})
              - $signed({req_i.prefix[rssc_pkg::SUM_W-1], req_i.prefix});
  assign low_ext  = $signed({{(rssc_pkg::DIFF_W - rssc_pkg::DATA_W)
                              {req_i.low[rssc_pkg::DATA_W-1]}}, req_i.low});
  assign high_ext = $signed({{(rssc_pkg::DIFF_W - rssc_pkg::DATA_W)
                              {req_i.high[rssc_pkg::DATA_W-1]}}, req_i.high});

  assign hit_o = (diff >= low_ext) && (diff <= high_ext);

endmodule

/* sv/range_sum_subarray_counter.sv */
// Range-sum subarray counter top level: APB registers, sequencer, store walk.
// Depends on rssc_pkg, rssc_prefix_mem, rssc_range_unit.
// The store walk, over at most MAX_LEN stored prefixes, runs through the single
// subtract-and-compare unit, one entry a cycle. A new item is accepted only in idle.
// Reset: control, running sum, counts and registers clear; the store is not cleared.
module range_sum_subarray_counter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [rssc_pkg::DATA_W-1:0]        sample_i,
  input  logic                               is_last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rssc_pkg::HERE_W-1:0]        matches_here_o,
  output logic [rssc_pkg::TOTAL_W-1:0]       total_matches_o,
  output logic                               overflowed_o,
  output logic                               end_of_sequence_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rssc_pkg::PADDR_W-1:0]       paddr,
  input  logic [rssc_pkg::DATA_W-1:0]        pwdata,
  output logic [rssc_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                       state_q, state_d;
  logic [rssc_pkg::DATA_W-1:0]      low_q, high_q;
  logic [rssc_pkg::DATA_W-1:0]      sample_q;
  logic                             last_q;
  logic [rssc_pkg::SUM_W-1:0]       run_q, run_d;
  logic [rssc_pkg::SUM_W-1:0]       sum_q;
  logic [rssc_pkg::CNT_W-1:0]       fill_q, fill_d;
  logic [rssc_pkg::CNT_W-1:0]       idx_q, idx_d;
  logic [rssc_pkg::TOTAL_W-1:0]     total_q, total_d;
  logic                             ovf_q, ovf_d;
  logic [rssc_pkg::HERE_W-1:0]      here_q, here_d;
  logic                             first_q, first_d;
  logic                             rvalid_q, rvalid_d;
  logic                             out_valid_q, out_valid_d;
  logic [rssc_pkg::HERE_W-1:0]      out_here_q;
  logic [rssc_pkg::TOTAL_W-1:0]     out_total_q;
  logic                             out_ovf_q, out_eos_q;

  logic                             cfg_wr, in_fire, rd_en, eval, hit, full, fire;
  logic [rssc_pkg::TOTAL_W:0]       total_sum;
  logic [rssc_pkg::TOTAL_W-1:0]     total_sat;
  logic [rssc_pkg::SUM_W-1:0]       rdata;
  rssc_pkg::mem_req_t               mem_req;
  rssc_pkg::cmp_req_t               cmp_req;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == rssc_pkg::REG_HIGH) ? high_q : low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        rssc_pkg::REG_LOW:  low_q  <= pwdata;
        rssc_pkg::REG_HIGH: high_q <= pwdata;
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign full  = (fill_q == rssc_pkg::CNT_W'(rssc_pkg::MAX_LEN));
  assign rd_en = (state_q == ST_SCAN) && (idx_q < fill_q);
  assign eval  = (state_q == ST_SCAN) && (first_q || rvalid_q);
  assign fire  = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign total_sum = {1'b0, total_q}
                   + {{(rssc_pkg::TOTAL_W + 1 - rssc_pkg::HERE_W){1'b0}}, here_q};
  assign total_sat = total_sum[rssc_pkg::TOTAL_W] ? rssc_pkg::TOTAL_MAX
                                                   : total_sum[rssc_pkg::TOTAL_W-1:0];

  assign cmp_req.sum    = sum_q;
  assign cmp_req.prefix = first_q ? '0 : rdata;
  assign cmp_req.low    = low_q;
  assign cmp_req.high   = high_q;

  assign mem_req.we    = fire && !full;
  assign mem_req.waddr = fill_q[rssc_pkg::ADDR_W-1:0];
  assign mem_req.wdata = sum_q;
  assign mem_req.re    = rd_en;
  assign mem_req.raddr = idx_q[rssc_pkg::ADDR_W-1:0];

  rssc_range_unit u_range (
    .req_i (cmp_req),
    .hit_o (hit)
  );

  rssc_prefix_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    run_d       = run_q;
    fill_d      = fill_q;
    total_d     = total_q;
    ovf_d       = ovf_q;
    idx_d       = idx_q;
    here_d      = here_q;
    first_d     = first_q;
    rvalid_d    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        idx_d   = '0;
        here_d  = '0;
        first_d = 1'b1;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        first_d  = 1'b0;
        rvalid_d = rd_en;
        idx_d    = idx_q + rssc_pkg::CNT_W'(rd_en);
        if (eval && hit && (here_q != rssc_pkg::HERE_MAX)) begin
          here_d = here_q + 1'b1;
        end
        if (!rd_en && !rvalid_q && !first_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (fire) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (last_q) begin
            run_d   = '0;
            fill_d  = '0;
            total_d = '0;
            ovf_d   = 1'b0;
          end else begin
            run_d   = sum_q;
            fill_d  = full ? fill_q : fill_q + 1'b1;
            total_d = total_sat;
            ovf_d   = ovf_q || full;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= '0;
      fill_q      <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      here_q      <= '0;
      first_q     <= 1'b0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      here_q      <= here_d;
      first_q     <= first_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= sample_i;
      last_q   <= is_last_i;
    end
    if (state_q == ST_SUM) begin
      sum_q <= run_q + {{(rssc_pkg::SUM_W - rssc_pkg::DATA_W){sample_q[rssc_pkg::DATA_W-1]}},
                        sample_q};
    end
    if (fire) begin
      out_here_q  <= here_q;
      out_total_q <= total_sat;
      out_ovf_q   <= ovf_q || full;
      out_eos_q   <= last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign matches_here_o    = out_here_q;
  assign total_matches_o   = out_total_q;
  assign overflowed_o      = out_ovf_q;
  assign end_of_sequence_o = out_eos_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= rssc_pkg::CNT_W'(rssc_pkg::MAX_LEN))
    else $error("fill count beyond store depth");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full)
    else $error("overflow flag set with store not full");

  a_here_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ({1'b0, here_q} <= {1'b0, fill_q} + 1'b1))
    else $error("match count exceeds stored prefixes");

  a_accept_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_SUM))
    else $error("accepted item did not start summing");

  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("finished item not presented");

endmodule

/* dv/range_sum_subarray_counter_tb.sv */
`timescale 1ns / 1ps
// Testbench for range_sum_subarray_counter: random and directed sequences, APB range setup,
// and a scoreboard class that predicts each result item. Depends on rssc_pkg and the RTL.
module range_sum_subarray_counter_tb;

  localparam int unsigned LIMIT = 4_000_000;

  typedef enum int {MIX_SMALL, MIX_MEDIUM, MIX_FULL, MIX_EXTREME} mix_e;

  typedef struct {
    logic [rssc_pkg::HERE_W-1:0]  here;
    logic [rssc_pkg::TOTAL_W-1:0] total;
    logic                         ovf;
    logic                         eos;
  } tally_t;

  class range_count_board;
    logic signed [rssc_pkg::SUM_W-1:0] prefix_sums [rssc_pkg::MAX_LEN];
    logic signed [rssc_pkg::SUM_W-1:0] run_sum;
    int unsigned fill;
    int unsigned total;
    bit ovf;
    int lo;
    int hi;
    int errors;
    tally_t pending_tallies[$];

    function new();
      run_sum = '0;
      fill = 0;
      total = 0;
      ovf = 0;
      lo = 0;
      hi = 0;
      errors = 0;
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch on %s: got %0d, wanted %0d", what, got, want);
      errors++;
    endtask

    function void set_bound(logic sel, logic [rssc_pkg::DATA_W-1:0] value);
      if (sel == rssc_pkg::REG_LOW) lo = value;
      else hi = value;
    endfunction

    function bit in_bounds(longint d);
      return d >= lo && d <= hi;
    endfunction

    function void note_item(logic [rssc_pkg::DATA_W-1:0] smp, logic last);
      logic signed [rssc_pkg::SUM_W-1:0] s;
      int unsigned here;
      tally_t t;
      s = run_sum + {{(rssc_pkg::SUM_W-rssc_pkg::DATA_W){smp[rssc_pkg::DATA_W-1]}}, smp};
      run_sum = s;
      here = in_bounds(longint'(s)) ? 1 : 0;
      for (int i = 0; i < fill; i++)
        if (in_bounds(longint'(s) - longint'(prefix_sums[i])) && here < rssc_pkg::HERE_MAX)
          here++;
      total = total + here;
      if (total > rssc_pkg::TOTAL_MAX) total = rssc_pkg::TOTAL_MAX;
      if (fill < rssc_pkg::MAX_LEN) begin
        prefix_sums[fill] = s;
        fill++;
      end else begin
        ovf = 1;
      end
      t.here = rssc_pkg::HERE_W'(here);
      t.total = rssc_pkg::TOTAL_W'(total);
      t.ovf = ovf;
      t.eos = last;
      pending_tallies.insert(pending_tallies.size(), t);
      if (last) begin
        run_sum = '0;
        fill = 0;
        total = 0;
        ovf = 0;
      end
    endfunction

    task check_result(logic [rssc_pkg::HERE_W-1:0] here, logic [rssc_pkg::TOTAL_W-1:0] tot,
                      logic ovf_o, logic eos);
      tally_t t;
      if (pending_tallies.size() == 0) begin
        report("result item with nothing pending", here, 0);
        return;
      end
      t = pending_tallies.pop_front();
      if (here !== t.here) report("matches_here", here, t.here);
      if (tot !== t.total) report("total_matches", tot, t.total);
      if (ovf_o !== t.ovf) report("overflowed", ovf_o, t.ovf);
      if (eos !== t.eos) report("end_of_sequence", eos, t.eos);
    endtask

    task check_readback(logic sel, logic [rssc_pkg::DATA_W-1:0] got);
      logic [rssc_pkg::DATA_W-1:0] want;
      want = (sel == rssc_pkg::REG_LOW) ? lo : hi;
      if (got !== want) report("register readback", got, want);
    endtask

    task flush();
      if (pending_tallies.size() != 0)
        report("result items never delivered", pending_tallies.size(), 0);
    endtask
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [rssc_pkg::DATA_W-1:0]   sample_i = '0;
  logic                          is_last_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [rssc_pkg::HERE_W-1:0]   matches_here_o;
  logic [rssc_pkg::TOTAL_W-1:0]  total_matches_o;
  logic                          overflowed_o;
  logic                          end_of_sequence_o;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [rssc_pkg::PADDR_W-1:0]  paddr = '0;
  logic [rssc_pkg::DATA_W-1:0]   pwdata = '0;
  logic [rssc_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  range_count_board board;
  bit quiet = 1'b0;
  int stall_left = 0;
  int unsigned cycle_count = 0;

  range_sum_subarray_counter uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .sample_i, .is_last_i,
    .out_valid_o, .out_ready_i, .matches_here_o, .total_matches_o, .overflowed_o,
    .end_of_sequence_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_item(sample_i, is_last_i);
      if (out_valid_o && out_ready_i)
        board.check_result(matches_here_o, total_matches_o, overflowed_o, end_of_sequence_o);
    end
  end

  // sink back-pressure: out_ready_i is dropped in random short bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_item(logic [rssc_pkg::DATA_W-1:0] smp, logic last);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 3);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= smp;
    is_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic stop_items();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending_tallies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_bound(logic sel, logic [rssc_pkg::DATA_W-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_bound(sel, value);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_bound(logic sel);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {sel, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.check_readback(sel, prdata);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // only called with the block idle
  task automatic set_range(logic [rssc_pkg::DATA_W-1:0] lo, logic [rssc_pkg::DATA_W-1:0] hi);
    stop_items();
    drain();
    write_bound(rssc_pkg::REG_LOW, lo);
    write_bound(rssc_pkg::REG_HIGH, hi);
    check_bound(rssc_pkg::REG_LOW);
    check_bound(rssc_pkg::REG_HIGH);
  endtask

  function automatic logic [rssc_pkg::DATA_W-1:0] pick_sample(mix_e mix);
    case (mix)
      MIX_SMALL:  return $urandom_range(0, 8) - 4;
      MIX_MEDIUM: return $urandom_range(0, 2000) - 1000;
      MIX_FULL:   return $urandom();
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  initial begin
    int seq_left;
    mix_e mix;
    logic [rssc_pkg::DATA_W-1:0] lo;
    logic [rssc_pkg::DATA_W-1:0] hi;

    board = new();
    seq_left = 0;
    mix = MIX_SMALL;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset range is [0, 0]
    check_bound(rssc_pkg::REG_LOW);
    check_bound(rssc_pkg::REG_HIGH);
    send_item(32'd0, 1'b0);
    send_item(32'd0, 1'b0);
    send_item(32'd0, 1'b1);
    send_item(32'd5, 1'b0);
    send_item(-32'sd5, 1'b1);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'd1, 1'b1);

    set_range(-32'sd3, 32'sd3);
    send_item(32'd1, 1'b0);
    send_item(-32'sd2, 1'b0);
    send_item(32'd3, 1'b0);
    send_item(-32'sd4, 1'b0);
    send_item(32'd2, 1'b1);

    // empty range
    set_range(32'sd3, -32'sd3);
    send_item(32'd1, 1'b0);
    send_item(32'd0, 1'b0);
    send_item(-32'sd1, 1'b1);

    set_range(32'h8000_0000, 32'h7FFF_FFFF);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b1);

    // sequences run across range changes on purpose
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin lo = -32'sd3; hi = 32'sd3; end
        1: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
        2: begin lo = '0; hi = '0; end
        3: begin lo = 32'h7FFF_FFFF; hi = 32'h7FFF_FFFF; end
        4: begin lo = 32'h8000_0000; hi = 32'h8000_0000; end
        5: begin lo = $urandom(); hi = $urandom(); end
        6: begin lo = $urandom_range(0, 20) - 10; hi = lo + $urandom_range(0, 20); end
        default: begin lo = 32'sd5; hi = -32'sd5; end
      endcase
      set_range(lo, hi);
      quiet = (phase == 2) || (phase == 7);
      for (int k = 0; k < 70; k++) begin
        if (seq_left == 0) begin
          seq_left = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 80)
                                                 : $urandom_range(1, 12);
          mix = mix_e'($urandom_range(0, 3));
        end
        seq_left--;
        send_item(pick_sample(mix), seq_left == 0);
      end
    end
    if (seq_left != 0) send_item(pick_sample(mix), 1'b1);

    stop_items();
    drain();
    repeat (rssc_pkg::MAX_LEN + 8) @(posedge clk_i);
    board.flush();
    if (board.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
sv/rssc_pkg.sv
sv/rssc_prefix_mem.sv
sv/rssc_range_unit.sv
sv/range_sum_subarray_counter.sv
dv/range_sum_subarray_counter_tb.sv
